@@ rtl/core/irpfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpfd_pkg
// Shared constants and types for the IR pulse-frame decoder.
// ----------------------------------------------------------------------------
package irpfd_pkg;

   localparam int PULSE_BITS_DEFAULT = 20;

   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_UNIT     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ADDR_FILTER   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ADDR_BIT_CNT  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CMD_BIT_CNT   = 2'd3;

   localparam logic [15:0] BASE_UNIT_RESET   = 16'd600;
   localparam logic [15:0] ADDR_FILTER_ANY   = 16'hFFFF;
   localparam logic [4:0]  ADDR_BITS_RESET   = 5'd5;
   localparam logic [4:0]  CMD_BITS_RESET    = 5'd7;
   localparam logic [4:0]  MAX_FIELD_BITS    = 5'd16;
   localparam logic [6:0]  PULSE_INDEX_MAX   = 7'd127;

   // duration class of one pulse, relative to the base unit
   typedef struct packed {
      logic near4;
      logic near2;
      logic near1;
   } pulse_match_type;

   // decoded frame result
   typedef struct packed {
      logic        good;
      logic [15:0] cmd;
      logic [15:0] addr;
   } frame_result_type;

endpackage : irpfd_pkg
`default_nettype wire

@@ rtl/core/irpfd_pulse_class.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpfd_pulse_class
// Tests one pulse duration against 1, 2 and 4 base units, +/- half a unit.
// ----------------------------------------------------------------------------
module irpfd_pulse_class
   import irpfd_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEFAULT
) (
   input  wire logic [PULSE_BITS-1:0] pulse_length,
   input  wire logic [15:0]           base_unit,
   output pulse_match_type            match
);

   // 4 * base_unit needs 18 bits
   localparam int DW = (PULSE_BITS > 18) ? PULSE_BITS : 18;

   logic [DW-1:0] dur;
   logic [DW-1:0] nom1;
   logic [DW-1:0] nom2;
   logic [DW-1:0] nom4;
   logic [DW-1:0] tol;
   logic [DW-1:0] diff1;
   logic [DW-1:0] diff2;
   logic [DW-1:0] diff4;

   always_comb begin
      dur  = DW'(pulse_length);
      nom1 = DW'(base_unit);
      nom2 = DW'({base_unit, 1'b0});
      nom4 = DW'({base_unit, 2'b00});
      tol  = DW'(base_unit[15:1]);
      diff1 = (dur >= nom1) ? (dur - nom1) : (nom1 - dur);
      diff2 = (dur >= nom2) ? (dur - nom2) : (nom2 - dur);
      diff4 = (dur >= nom4) ? (dur - nom4) : (nom4 - dur);
      match.near1 = (diff1 <= tol);
      match.near2 = (diff2 <= tol);
      match.near4 = (diff4 <= tol);
   end

endmodule : irpfd_pulse_class
`default_nettype wire

@@ rtl/core/irpfd_frame_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpfd_frame_acc
// Frame state: pulse counter, command/address shift, error flag.
// ----------------------------------------------------------------------------
module irpfd_frame_acc
   import irpfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,          // pulse consumed this cycle
   input  wire logic        last,
   input  pulse_match_type  match,
   input  wire logic [15:0] address_filter,
   input  wire logic [4:0]  address_bit_count,
   input  wire logic [4:0]  command_bit_count,
   output frame_result_type result
);

   logic [6:0]  pulse_index_ff, pulse_index_in;
   logic [15:0] command_shift_ff, command_shift_in;
   logic [15:0] address_shift_ff, address_shift_in;
   logic        frame_error_ff, frame_error_in;

   logic [4:0]  na;
   logic [4:0]  nc;
   logic [6:0]  needed;
   logic [5:0]  k;
   logic [5:0]  ka;
   logic [6:0]  idx_next;
   logic        err_n;
   logic [15:0] cmd_n;
   logic [15:0] addr_n;
   logic        good;

   always_comb begin
      na = (address_bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : address_bit_count;
      nc = (command_bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : command_bit_count;
      needed = 7'd1 + {({1'b0, na} + {1'b0, nc}), 1'b0};
      k  = pulse_index_ff[6:1] - 6'd1;   // bit number on a mark pulse
      ka = k - {1'b0, nc};
      err_n  = frame_error_ff;
      cmd_n  = command_shift_ff;
      addr_n = address_shift_ff;

      if (pulse_index_ff == 7'd0) begin
         if (!match.near4) err_n = 1'b1;
      end else if ((pulse_index_ff < needed) && !frame_error_ff) begin
         if (pulse_index_ff[0]) begin
            if (!match.near1) err_n = 1'b1;   // space
         end else if (match.near2) begin
            if (k < {1'b0, nc}) begin
               cmd_n[k[3:0]] = 1'b1;
            end else if (ka < {1'b0, na}) begin
               addr_n[ka[3:0]] = 1'b1;
            end
         end else if (!match.near1) begin
            err_n = 1'b1;
         end
      end

      idx_next = (pulse_index_ff == PULSE_INDEX_MAX) ? pulse_index_ff
                                                     : pulse_index_ff + 7'd1;

      good = !err_n && (idx_next >= needed) &&
             ((addr_n == address_filter) || (address_filter == ADDR_FILTER_ANY));
      result.good = good;
      result.addr = good ? addr_n : 16'd0;
      result.cmd  = good ? cmd_n : 16'd0;

      pulse_index_in   = pulse_index_ff;
      command_shift_in = command_shift_ff;
      address_shift_in = address_shift_ff;
      frame_error_in   = frame_error_ff;
      if (step) begin
         if (last) begin
            pulse_index_in   = 7'd0;
            command_shift_in = 16'd0;
            address_shift_in = 16'd0;
            frame_error_in   = 1'b0;
         end else begin
            pulse_index_in   = idx_next;
            command_shift_in = cmd_n;
            address_shift_in = addr_n;
            frame_error_in   = err_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_index_ff   <= 7'd0;
         command_shift_ff <= 16'd0;
         address_shift_ff <= 16'd0;
         frame_error_ff   <= 1'b0;
      end else begin
         pulse_index_ff   <= pulse_index_in;
         command_shift_ff <= command_shift_in;
         address_shift_ff <= address_shift_in;
         frame_error_ff   <= frame_error_in;
      end
   end

endmodule : irpfd_frame_acc
`default_nettype wire

@@ rtl/core/ir_remote_pulse_frame_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_remote_pulse_frame_decoder_top
// Pulse-width IR remote frame decoder with stream request/response ports.
// ----------------------------------------------------------------------------
// Each request carries one measured pulse duration; tlast marks the final
// pulse of a frame. Pulse 0 must be a 4-unit sync mark, then space/mark
// pairs follow (space 1 unit, mark 2 units = 1, 1 unit = 0), command bits
// first, then address bits, LSB first. A duration matches a nominal length
// when it is within half a base unit, inclusive. Exactly one response leaves
// per frame, on its last pulse: tuser is frame_good, tdata the decoded
// address and command (both zero on a failed frame). Pulses past the needed
// count are ignored. Throughput is one request per clock while the input
// register does not stall (see below); a pulse is loaded into the input
// register when accepted and decoded from there into the output register;
// a last pulse moves on only once the output register is free.
// The input register stalls only when a finished response is still waiting
// in the output register and the next pulse to retire is also a last pulse.
// CSRs (base unit, address filter, bit counts) are written through csr_* and
// must only change while no frame is in flight.
// ----------------------------------------------------------------------------
module ir_remote_pulse_frame_decoder_top
   import irpfd_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request: tdata = pulse_length (zero padded to bytes)
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [((PULSE_BITS+7)/8)*8-1:0]    req_tdata,
   input  wire logic                               req_tlast,   // last_pulse
   // response: tdata = device_address [15:0], command_code [31:16]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [31:0]                             rsp_tdata,
   output logic                                    rsp_tuser,   // frame_good
   // CSR write port
   input  wire logic                               csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]            csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]           csr_wdata
);

   // ---- configuration registers ----
   logic [15:0] base_unit_ff;
   logic [15:0] addr_filter_ff;
   logic [4:0]  addr_bits_ff;
   logic [4:0]  cmd_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_unit_ff   <= BASE_UNIT_RESET;
         addr_filter_ff <= ADDR_FILTER_ANY;
         addr_bits_ff   <= ADDR_BITS_RESET;
         cmd_bits_ff    <= CMD_BITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_UNIT:    base_unit_ff   <= csr_wdata;
            CSR_ADDR_FILTER:  addr_filter_ff <= csr_wdata;
            CSR_ADDR_BIT_CNT: addr_bits_ff   <= csr_wdata[4:0];
            CSR_CMD_BIT_CNT:  cmd_bits_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // ---- input register ----
   logic                  s1_valid_ff, s1_valid_in;
   logic [PULSE_BITS-1:0] s1_pulse_ff;
   logic                  s1_last_ff;
   logic                  out_valid_ff, out_valid_in;
   frame_result_type      out_ff;
   frame_result_type      result;
   pulse_match_type       match;
   logic                  out_free;
   logic                  s1_adv;
   logic                  req_fire;

   assign out_free   = !out_valid_ff || rsp_tready;
   // a non-last pulse only updates frame state, so it never waits on the output
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pulse_ff <= req_tdata[PULSE_BITS-1:0];
         s1_last_ff  <= req_tlast;
      end
   end

   // ---- decode ----
   irpfd_pulse_class #(
      .PULSE_BITS (PULSE_BITS)
   ) u_class (
      .pulse_length (s1_pulse_ff),
      .base_unit    (base_unit_ff),
      .match        (match)
   );

   irpfd_frame_acc u_acc (
      .clock             (clock),
      .reset             (reset),
      .step              (s1_adv),
      .last              (s1_last_ff),
      .match             (match),
      .address_filter    (addr_filter_ff),
      .address_bit_count (addr_bits_ff),
      .command_bit_count (cmd_bits_ff),
      .result            (result)
   );

   // ---- output register ----
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.good;
   assign rsp_tdata  = {out_ff.cmd, out_ff.addr};

   // ---- assertions ----
   // a retired last pulse always lands a response
   a_last_makes_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> rsp_tvalid)
      else $error("last pulse retired without a response");

   // a failed frame reports zero address and command
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("failed frame carries nonzero payload");

   // a good frame honors the address filter
   a_good_filter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (addr_filter_ff == ADDR_FILTER_ANY) || (rsp_tdata[15:0] == addr_filter_ff))
      else $error("good frame with mismatched address");

   // a last pulse never retires over an unaccepted response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |-> out_free)
      else $error("response overwritten");

endmodule : ir_remote_pulse_frame_decoder_top
`default_nettype wire

@@ bench/tb_ir_remote_pulse_frame_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_remote_pulse_frame_decoder_top
// Self-checking bench for the IR pulse-frame decoder: pulse frames are streamed
// in, and each response is scored against a cycle-free decoder model.
// ----------------------------------------------------------------------------
module tb_ir_remote_pulse_frame_decoder_top;
   import irpfd_pkg::*;

   localparam int PULSE_BITS  = PULSE_BITS_DEFAULT;
   localparam int REQ_W       = ((PULSE_BITS + 7) / 8) * 8;
   localparam int PULSE_MAX   = (1 << PULSE_BITS) - 1;
   localparam int HOLD_CYCLES = 300;        // long receiver back-pressure stretch
   localparam int DRAIN_LIMIT = 2000;       // cycles allowed for late responses

   // nominal pulse lengths in base units
   localparam int SYNC_UNITS      = 4;
   localparam int SPACE_UNITS     = 1;
   localparam int MARK_ONE_UNITS  = 2;
   localparam int MARK_ZERO_UNITS = 1;

   typedef struct packed {
      logic [PULSE_BITS-1:0] len;
      logic                  is_last;
   } pulse_req_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata  = '0;   // pulse_length
   logic                    req_tlast  = 1'b0; // last_pulse
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [31:0]             rsp_tdata;         // device_address, command_code
   logic                    rsp_tuser;         // frame_good
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index  = CSR_BASE_UNIT;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   ir_remote_pulse_frame_decoder_top #(
      .PULSE_BITS (PULSE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // pulses still to send, and decoded frames still owed by the DUT
   pulse_req_type    pulse_queue[$];
   frame_result_type expected_frames[$];
   pulse_req_type    next_req;
   int               error_count = 0;

   // traffic shaping, set by the sequencer between phases
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_req      = 1'b0;
   int   hold_cycles   = 0;

   // configuration the sequencer builds frames for
   int          plan_base;
   logic [15:0] plan_filter;
   int          plan_abits;
   int          plan_cbits;

   // decoder model: configuration copy, taken from observed CSR writes
   logic [15:0] unit_ticks;
   logic [15:0] addr_filter;
   logic [4:0]  addr_bits;
   logic [4:0]  cmd_bits;
   // decoder model: frame state
   logic [6:0]  dec_index;
   logic [15:0] dec_cmd;
   logic [15:0] dec_addr;
   logic        dec_err;

   function automatic logic near_units(input logic [PULSE_BITS-1:0] len, input int units);
      logic [63:0] nom;
      logic [63:0] tol;
      logic [63:0] diff;
      nom  = 64'(unit_ticks) * 64'(units);
      tol  = 64'(unit_ticks) >> 1;
      diff = (64'(len) >= nom) ? 64'(len) - nom : nom - 64'(len);
      return diff <= tol;
   endfunction

   // advance the model by one accepted pulse; a last pulse yields a frame result
   task automatic decode_pulse(input logic [PULSE_BITS-1:0] len, input logic is_last);
      int               na;
      int               nc;
      int               needed;
      int               k;
      logic             bit_one;
      logic             good;
      frame_result_type res;
      na     = (addr_bits > MAX_FIELD_BITS) ? 16 : int'(addr_bits);
      nc     = (cmd_bits > MAX_FIELD_BITS) ? 16 : int'(cmd_bits);
      needed = 1 + 2 * (na + nc);
      if (dec_index == 0) begin
         if (!near_units(len, SYNC_UNITS)) dec_err = 1'b1;
      end else if (int'(dec_index) < needed && !dec_err) begin
         k = (int'(dec_index) - 1) / 2;
         if (dec_index[0]) begin
            if (!near_units(len, SPACE_UNITS)) dec_err = 1'b1;
         end else begin
            // 2-unit test wins where both nominal windows overlap
            bit_one = near_units(len, MARK_ONE_UNITS);
            if (!bit_one && !near_units(len, MARK_ZERO_UNITS)) dec_err = 1'b1;
            if (bit_one) begin
               if (k < nc) dec_cmd[k] = 1'b1;
               else if (k - nc < na) dec_addr[k - nc] = 1'b1;
            end
         end
      end
      if (dec_index < PULSE_INDEX_MAX) dec_index++;
      if (is_last) begin
         good = !dec_err && int'(dec_index) >= needed &&
                (dec_addr == addr_filter || addr_filter == ADDR_FILTER_ANY);
         res.good = good;
         res.addr = good ? dec_addr : 16'h0;
         res.cmd  = good ? dec_cmd : 16'h0;
         expected_frames.push_back(res);
         dec_index = '0;
         dec_cmd   = '0;
         dec_addr  = '0;
         dec_err   = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   // Scoreboard: tracks CSR writes, scores responses, then feeds accepted
   // requests to the model. All sampling is at the rising edge, before any
   // stimulus update of the same edge lands.
   always @(posedge clock) begin
      if (reset) begin
         unit_ticks  = BASE_UNIT_RESET;
         addr_filter = ADDR_FILTER_ANY;
         addr_bits   = ADDR_BITS_RESET;
         cmd_bits    = CMD_BITS_RESET;
         dec_index   = '0;
         dec_cmd     = '0;
         dec_addr    = '0;
         dec_err     = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_UNIT:    unit_ticks  = csr_wdata;
               CSR_ADDR_FILTER:  addr_filter = csr_wdata;
               CSR_ADDR_BIT_CNT: addr_bits   = csr_wdata[4:0];
               CSR_CMD_BIT_CNT:  cmd_bits    = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               error_count++;
               $display("%0t: response with no frame pending: good=%0b data=%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               frame_result_type exp_res;
               exp_res = expected_frames.pop_front();
               check_field("frame_good", 16'(exp_res.good), 16'(rsp_tuser));
               check_field("device_address", exp_res.addr, rsp_tdata[15:0]);
               check_field("command_code", exp_res.cmd, rsp_tdata[31:16]);
            end
         end
         if (req_tvalid && req_tready)
            decode_pulse(req_tdata[PULSE_BITS-1:0], req_tlast);
      end
   end

   // Request driver: presents the next queued pulse once the current one is
   // taken, with random gaps at the phase's idle rate.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pulse_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pulse_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'(next_req.len);
            req_tlast  <= next_req.is_last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls, plus one long hold-off once requested so
   // the output and input registers fill and the DUT pushes back on requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && hold_cycles < HOLD_CYCLES) begin
         hold_cycles++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic push_pulse(input int len, input logic is_last);
      pulse_req_type p;
      p.len     = PULSE_BITS'(len);
      p.is_last = is_last;
      pulse_queue.push_back(p);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Wait until every queued pulse is taken and every frame answered, then
   // let the pipeline retire any trailing non-last pulse.
   task automatic wait_drained();
      do @(negedge clock);
      while (pulse_queue.size() != 0 || req_tvalid || expected_frames.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_phase(input int base, input int filt, input int abits,
                            input int cbits, input int s_idle, input int r_stall,
                            input logic hold);
      wait_drained();
      write_csr(CSR_BASE_UNIT, base);
      write_csr(CSR_ADDR_FILTER, filt);
      write_csr(CSR_ADDR_BIT_CNT, abits);
      write_csr(CSR_CMD_BIT_CNT, cbits);
      @(negedge clock);
      plan_base     = base;
      plan_filter   = 16'(filt);
      plan_abits    = abits;
      plan_cbits    = cbits;
      send_idle_pct = s_idle;
      rsp_stall_pct = r_stall;
      if (hold) hold_req = 1'b1;
   endtask

   // One random frame under the planned configuration. Mostly well formed
   // with random address/command; the rest has extra pulses (occasionally
   // enough to saturate the pulse counter), is cut short, or has one bad pulse.
   task automatic add_frame(inout int added);
      int          na;
      int          nc;
      int          needed;
      int          n_send;
      int          bad_at;
      int          tol;
      int          kind;
      int          i;
      int          k;
      int          units;
      int          nom;
      int          len;
      logic        bit_v;
      logic [15:0] amask;
      logic [15:0] cmask;
      logic [15:0] cmd;
      logic [15:0] addr;
      na     = (plan_abits > 16) ? 16 : plan_abits;
      nc     = (plan_cbits > 16) ? 16 : plan_cbits;
      needed = 1 + 2 * (na + nc);
      tol    = plan_base / 2;
      amask  = 16'((32'h1 << na) - 1);
      cmask  = 16'((32'h1 << nc) - 1);
      cmd    = 16'($urandom) & cmask;
      addr   = 16'($urandom) & amask;
      if (plan_filter != ADDR_FILTER_ANY && $urandom_range(99) < 70)
         addr = plan_filter & amask;
      n_send = needed;
      bad_at = -1;
      kind   = $urandom_range(99);
      if (kind >= 65 && kind < 75) begin
         n_send = needed + $urandom_range(4, 1);
         if ($urandom_range(14) == 0) n_send += $urandom_range(130, 100);
      end else if (kind >= 75 && kind < 85) begin
         if (needed > 1) n_send = $urandom_range(needed - 1, 1);
      end else if (kind >= 85) begin
         bad_at = $urandom_range(needed - 1);
      end
      for (i = 0; i < n_send; i++) begin
         if (i >= needed) begin
            len = $urandom_range(PULSE_MAX);
         end else begin
            if (i == 0) begin
               units = SYNC_UNITS;
            end else if (i % 2 == 1) begin
               units = SPACE_UNITS;
            end else begin
               k = (i - 2) / 2;
               if (k < nc) bit_v = cmd[k];
               else bit_v = addr[k - nc];
               units = bit_v ? MARK_ONE_UNITS : MARK_ZERO_UNITS;
            end
            nom = units * plan_base;
            if (i == bad_at) begin
               // either wild or just outside the tolerance window
               if ($urandom_range(1)) len = $urandom_range(PULSE_MAX);
               else if ($urandom_range(1)) len = nom + tol + 1;
               else len = nom - tol - 1;
            end else begin
               len = nom + int'($urandom_range(2 * tol)) - tol;
            end
         end
         push_pulse(len, i == n_send - 1);
      end
      added += n_send;
   endtask

   task automatic run_random(input int n_items);
      int added;
      added = 0;
      while (added < n_items) add_frame(added);
   endtask

   // Sequencer
   initial begin
      int drain_cycles;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: one command bit, one address bit, base of 100 ticks.
      set_phase(100, ADDR_FILTER_ANY, 1, 1, 0, 0, 1'b0);
      // both marks on window edges; 150 sits in both windows and decodes as 1
      push_pulse(400, 1'b0); push_pulse(100, 1'b0); push_pulse(150, 1'b0);
      push_pulse(50, 1'b0);  push_pulse(250, 1'b1);
      // frame cut short
      push_pulse(400, 1'b0); push_pulse(100, 1'b0); push_pulse(200, 1'b1);
      // zero-length sync, saturated pulse later on
      push_pulse(0, 1'b0);   push_pulse(100, 1'b0); push_pulse(100, 1'b0);
      push_pulse(100, 1'b0); push_pulse(PULSE_MAX, 1'b1);
      // mark of three units is no valid bit
      push_pulse(400, 1'b0); push_pulse(100, 1'b0); push_pulse(300, 1'b0);
      push_pulse(100, 1'b0); push_pulse(100, 1'b1);
      // good frame followed by ignored extra pulses
      push_pulse(400, 1'b0); push_pulse(100, 1'b0); push_pulse(100, 1'b0);
      push_pulse(100, 1'b0); push_pulse(200, 1'b0); push_pulse(PULSE_MAX, 1'b0);
      push_pulse(0, 1'b1);
      // lone sync as the last pulse
      push_pulse(400, 1'b1);

      // Random phases: configuration extremes across idle/stall mixes.
      // Reset-value config, no idling, with the long receiver hold-off.
      set_phase(600, ADDR_FILTER_ANY, 5, 7, 0, 0, 1'b1);
      run_random(250);
      // smallest base unit, specific address filter
      set_phase(2, 16'h001A, 5, 7, 47, 0, 1'b0);
      run_random(250);
      // largest base unit, widest fields
      set_phase(65535, ADDR_FILTER_ANY, 16, 16, 0, 47, 1'b0);
      run_random(400);
      // no bits at all: sync-only frames, filter of zero
      set_phase(37, 16'h0000, 0, 0, 21, 21, 1'b0);
      run_random(250);
      // counts above 16 are clamped
      set_phase(1000, 16'h00FF, 31, 20, 0, 0, 1'b0);
      run_random(250);
      set_phase(9, 16'hABCD, 16, 3, 47, 0, 1'b0);
      run_random(250);
      set_phase(65535, ADDR_FILTER_ANY, 0, 0, 0, 47, 1'b0);
      run_random(250);
      set_phase(601, 16'h0003, 2, 1, 21, 21, 1'b0);
      run_random(250);

      // all requests out, then let outstanding responses come back
      do @(negedge clock);
      while (pulse_queue.size() != 0 || req_tvalid);
      drain_cycles = 0;
      while (expected_frames.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (10) @(negedge clock);
      if (expected_frames.size() != 0) begin
         error_count++;
         $display("%0t: %0d frame results never arrived", $time, expected_frames.size());
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #6000000;
      $display("FAIL");
      $finish;
   end

endmodule
